// File: hw/rtl/lfu_pkg.sv
// Shared constants, types and codes of the LFU cache table.
`default_nettype none
package lfu_pkg;

    localparam int CAPACITY_MAX = 16;
    localparam int IDX_W        = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
    localparam int OCC_W        = $clog2(CAPACITY_MAX + 1);
    localparam int CFG_W        = 5;
    localparam int KEY_W        = 32;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = 32;
    localparam int STAMP_W      = 64;

    localparam logic [CFG_W-1:0]  CAP_RESET  = CFG_W'(16);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;
    localparam logic [DATA_W-1:0] PUT_VALUE  = '0;
    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
    localparam logic [CNT_W-1:0]  CNT_FIRST  = CNT_W'(1);

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // entry under check in the scan pipeline
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic             ent_vld;
    } t_chk;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [DATA_W-1:0] hit_data;
        logic [CNT_W-1:0]  hit_count;
        logic              vic_vld;
        logic [IDX_W-1:0]  vic_idx;
        logic              free_vld;
        logic [IDX_W-1:0]  free_idx;
    } t_scan_stat;

endpackage
`default_nettype wire

// File: hw/rtl/lfu_if.sv
// Request and response channel interfaces of the LFU cache table.
`default_nettype none
interface lfu_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;

    modport source (output valid, output opcode, output lookup_key, output store_value,
                    input ready);
    modport sink (input valid, input opcode, input lookup_key, input store_value,
                  output ready);
endinterface

interface lfu_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [31:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink (input valid, input found, input read_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lfu_ram.sv
// Simple dual-port synchronous RAM with registered read.
`default_nettype none
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/lfu_scan.sv
// Scan tracker: first key match, LFU/LRU victim and first free slot.
`default_nettype none
module lfu_scan (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire lfu_pkg::t_chk             i_chk,
    input  wire lfu_pkg::t_entry           i_entry,
    input  wire logic [lfu_pkg::KEY_W-1:0] i_key,
    output lfu_pkg::t_scan_stat            o_stat
);

    logic                          r_hit;
    logic [lfu_pkg::IDX_W-1:0]     r_hit_idx;
    logic [lfu_pkg::DATA_W-1:0]    r_hit_data;
    logic [lfu_pkg::CNT_W-1:0]     r_hit_count;
    logic                          r_vic_vld;
    logic [lfu_pkg::IDX_W-1:0]     r_vic_idx;
    logic [lfu_pkg::CNT_W-1:0]     r_vic_count;
    logic [lfu_pkg::STAMP_W-1:0]   r_vic_stamp;
    logic                          r_free_vld;
    logic [lfu_pkg::IDX_W-1:0]     r_free_idx;

    logic take_hit;
    logic take_vic;
    logic take_free;

    always_comb begin
        take_hit  = i_chk.vld && i_chk.ent_vld && !r_hit && (i_entry.key == i_key);
        // lower count wins, older stamp breaks a tie
        take_vic  = i_chk.vld && i_chk.ent_vld &&
                    (!r_vic_vld || (i_entry.count < r_vic_count) ||
                     ((i_entry.count == r_vic_count) && (i_entry.stamp < r_vic_stamp)));
        take_free = i_chk.vld && !i_chk.ent_vld && !r_free_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_hit      <= 1'b0;
            r_vic_vld  <= 1'b0;
            r_free_vld <= 1'b0;
        end else begin
            if (take_hit) begin
                r_hit <= 1'b1;
            end
            if (take_vic) begin
                r_vic_vld <= 1'b1;
            end
            if (take_free) begin
                r_free_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_hit) begin
            r_hit_idx   <= i_chk.idx;
            r_hit_data  <= i_entry.data;
            r_hit_count <= i_entry.count;
        end
        if (take_vic) begin
            r_vic_idx   <= i_chk.idx;
            r_vic_count <= i_entry.count;
            r_vic_stamp <= i_entry.stamp;
        end
        if (take_free) begin
            r_free_idx <= i_chk.idx;
        end
    end

    always_comb begin
        o_stat.hit       = r_hit;
        o_stat.hit_idx   = r_hit_idx;
        o_stat.hit_data  = r_hit_data;
        o_stat.hit_count = r_hit_count;
        o_stat.vic_vld   = r_vic_vld;
        o_stat.vic_idx   = r_vic_idx;
        o_stat.free_vld  = r_free_vld;
        o_stat.free_idx  = r_free_idx;
    end

endmodule
`default_nettype wire

// File: hw/rtl/lfu_cache_table.sv
// Top level of the LFU cache table with LRU tie-break.
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        opcode, lookup_key, store_value
//  o_rsp     out  valid/ready        found, read_value
//  i_cfg     in   i_cfg_wr_en        i_cfg_wr_data (capacity_in_use)
//
// One word at a time: after accept, ST_SCAN reads every entry through the entry
// memory's single read port, ST_LAST takes the last read data and ST_FINISH does
// the write-back and loads the result. Reset clears valid bits, occupancy, the
// access clock and sets capacity to 16. A result waits in the output register;
// the next word is taken meanwhile and stalls in write-back while it is full.
`default_nettype none
module lfu_cache_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    lfu_req_if.sink                        i_req,
    lfu_rsp_if.source                      o_rsp,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [lfu_pkg::CFG_W-1:0] i_cfg_wr_data
);

    localparam int IDX_W = lfu_pkg::IDX_W;
    localparam int OCC_W = lfu_pkg::OCC_W;

    lfu_pkg::t_state                    r_state;
    lfu_pkg::t_state                    n_state;
    logic [lfu_pkg::CFG_W-1:0]          r_capacity;
    logic [lfu_pkg::CAPACITY_MAX-1:0]   r_valid;
    logic [OCC_W-1:0]                   r_occ;
    logic [lfu_pkg::STAMP_W-1:0]        r_clock;
    logic [IDX_W-1:0]                   r_addr;
    lfu_pkg::t_chk                      r_chk;
    lfu_pkg::t_op                       r_op;
    logic [lfu_pkg::KEY_W-1:0]          r_key;
    logic [lfu_pkg::DATA_W-1:0]         r_val;
    logic                               r_rsp_valid;
    logic                               r_found;
    logic [lfu_pkg::DATA_W-1:0]         r_value;

    lfu_pkg::t_entry                    rd_entry;
    lfu_pkg::t_entry                    wr_entry;
    lfu_pkg::t_scan_stat                stat;

    logic                               accept;
    logic                               rd_en;
    logic                               fin_go;
    logic                               ram_we;
    logic [IDX_W-1:0]                   wr_idx;
    logic                               set_valid;
    logic                               occ_inc;
    logic [OCC_W-1:0]                   cap;
    logic                               use_victim;
    logic                               n_found;
    logic [lfu_pkg::DATA_W-1:0]         n_value;

    assign i_req.ready = (r_state == lfu_pkg::ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.found      = r_found;
    assign o_rsp.read_value = r_value;

    always_comb begin
        if (32'(r_capacity) > 32'(lfu_pkg::CAPACITY_MAX)) begin
            cap = OCC_W'(lfu_pkg::CAPACITY_MAX);
        end else begin
            cap = OCC_W'(r_capacity);
        end
    end

    // state machine and write-back decision
    always_comb begin
        n_state    = r_state;
        rd_en      = 1'b0;
        fin_go     = 1'b0;
        ram_we     = 1'b0;
        wr_idx     = stat.hit_idx;
        set_valid  = 1'b0;
        occ_inc    = 1'b0;
        use_victim = (r_occ >= cap) && stat.vic_vld;
        n_found    = 1'b0;
        n_value    = lfu_pkg::PUT_VALUE;
        wr_entry.key   = r_key;
        wr_entry.data  = r_val;
        wr_entry.count = lfu_pkg::CNT_FIRST;
        wr_entry.stamp = r_clock;

        if (stat.hit) begin
            n_found = 1'b1;
            if (r_op == lfu_pkg::OP_GET) begin
                n_value       = stat.hit_data;
                wr_entry.data = stat.hit_data;
            end
            if (stat.hit_count != lfu_pkg::CNT_MAX) begin
                wr_entry.count = stat.hit_count + lfu_pkg::CNT_FIRST;
            end else begin
                wr_entry.count = stat.hit_count;
            end
        end else if (r_op == lfu_pkg::OP_GET) begin
            n_value = lfu_pkg::MISS_VALUE;
        end

        unique case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                rd_en = 1'b1;
                if (r_addr == IDX_W'(lfu_pkg::CAPACITY_MAX - 1)) begin
                    n_state = lfu_pkg::ST_LAST;
                end
            end
            lfu_pkg::ST_LAST: begin
                n_state = lfu_pkg::ST_FINISH;
            end
            lfu_pkg::ST_FINISH: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    fin_go  = 1'b1;
                    n_state = lfu_pkg::ST_IDLE;
                    if (stat.hit) begin
                        ram_we = 1'b1;
                    end else if (r_op == lfu_pkg::OP_PUT && cap != '0) begin
                        if (use_victim) begin
                            ram_we    = 1'b1;
                            wr_idx    = stat.vic_idx;
                            set_valid = 1'b1;
                        end else if (stat.free_vld) begin
                            ram_we    = 1'b1;
                            wr_idx    = stat.free_idx;
                            set_valid = 1'b1;
                            occ_inc   = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= lfu_pkg::CAP_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_clock     <= '0;
            r_addr      <= '0;
            r_chk       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (accept) begin
                r_addr <= '0;
            end else if (rd_en) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            r_chk.vld     <= rd_en;
            r_chk.idx     <= r_addr;
            r_chk.ent_vld <= r_valid[r_addr];
            if (set_valid) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (occ_inc) begin
                r_occ <= r_occ + OCC_W'(1);
            end
            if (ram_we) begin
                r_clock <= r_clock + lfu_pkg::STAMP_W'(1);
            end
            if (fin_go) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= lfu_pkg::t_op'(i_req.opcode);
            r_key <= i_req.lookup_key;
            r_val <= i_req.store_value;
        end
        if (fin_go) begin
            r_found <= n_found;
            r_value <= n_value;
        end
    end

    lfu_ram #(
        .WIDTH ($bits(lfu_pkg::t_entry)),
        .DEPTH (lfu_pkg::CAPACITY_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_entry)
    );

    lfu_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_chk   (r_chk),
        .i_entry (rd_entry),
        .i_key   (r_key),
        .o_stat  (stat)
    );

    // occupancy tracks the valid bits
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy differs from valid bit count");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == lfu_pkg::ST_SCAN) && (r_addr == '0))
        else $error("scan did not start at entry zero");

    a_rsp_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state) == lfu_pkg::ST_FINISH)
        else $error("response loaded outside write-back");

    a_hit_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfu_pkg::ST_FINISH) && stat.hit |-> r_valid[stat.hit_idx])
        else $error("hit on an invalid entry");

    a_victim_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_valid && !occ_inc |-> r_valid[wr_idx] && (r_occ >= cap))
        else $error("eviction without a full table");

endmodule
`default_nettype wire

// File: tb/sv/lfu_cache_table_tb.sv
// Self-checking testbench of the LFU cache table: directed and random get/put traffic.
`timescale 1ns / 1ps
module lfu_cache_table_tb;
    import lfu_pkg::*;

    localparam int QUIET_LIMIT     = 4000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 161;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] value;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    logic cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    lfu_req_if req_bus();
    lfu_rsp_if rsp_bus();

    lfu_cache_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .o_rsp         (rsp_bus),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // shadow copy of the cache table
    logic               ent_valid [CAPACITY_MAX];
    logic [KEY_W-1:0]   ent_key   [CAPACITY_MAX];
    logic [DATA_W-1:0]  ent_data  [CAPACITY_MAX];
    logic [CNT_W-1:0]   ent_uses  [CAPACITY_MAX];
    logic [STAMP_W-1:0] ent_stamp [CAPACITY_MAX];
    logic [STAMP_W-1:0] touch_clock;
    int                 occupancy;
    logic [CFG_W-1:0]   capacity_reg;

    t_answer pending_answers[$];

    int mismatches;
    int words_sent;
    int answers_checked;
    int capacity_writes;
    int sender_idle_pct;
    int receiver_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what);
        mismatches++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    function automatic void touch_entry(int slot);
        if (ent_uses[slot] != CNT_MAX)
            ent_uses[slot] = ent_uses[slot] + 1'b1;
        ent_stamp[slot] = touch_clock;
        touch_clock = touch_clock + 1'b1;
    endfunction

    // updates the shadow table and returns the answer for one word
    function automatic t_answer predict_access(t_op op, logic [KEY_W-1:0] key,
                                               logic [DATA_W-1:0] val);
        t_answer ans;
        int hit;
        int slot;
        int cap;
        cap = (capacity_reg > CAPACITY_MAX) ? CAPACITY_MAX : int'(capacity_reg);
        hit = -1;
        for (int i = CAPACITY_MAX - 1; i >= 0; i--)
            if (ent_valid[i] && ent_key[i] == key)
                hit = i;
        if (op == OP_GET) begin
            if (hit >= 0) begin
                ans.found = 1'b1;
                ans.value = ent_data[hit];
                touch_entry(hit);
            end else begin
                ans.found = 1'b0;
                ans.value = MISS_VALUE;
            end
            return ans;
        end
        ans.found = (hit >= 0);
        ans.value = PUT_VALUE;
        if (hit >= 0) begin
            ent_data[hit] = val;
            touch_entry(hit);
        end else if (cap != 0) begin
            slot = -1;
            if (occupancy >= cap) begin
                // lowest use count, oldest stamp on a tie
                for (int i = 0; i < CAPACITY_MAX; i++) begin
                    if (ent_valid[i] && (slot < 0 || ent_uses[i] < ent_uses[slot] ||
                        (ent_uses[i] == ent_uses[slot] && ent_stamp[i] < ent_stamp[slot])))
                        slot = i;
                end
                if (slot >= 0) begin
                    ent_valid[slot] = 1'b0;
                    occupancy--;
                end
            end
            if (slot < 0)
                for (int i = CAPACITY_MAX - 1; i >= 0; i--)
                    if (!ent_valid[i])
                        slot = i;
            if (slot >= 0) begin
                ent_valid[slot] = 1'b1;
                ent_key[slot]   = key;
                ent_data[slot]  = val;
                ent_uses[slot]  = CNT_FIRST;
                ent_stamp[slot] = touch_clock;
                touch_clock     = touch_clock + 1'b1;
                occupancy++;
            end
        end
        return ans;
    endfunction

    // called right after a rising edge; returns at the edge that accepts the word
    task automatic send_word(t_op op, logic [KEY_W-1:0] key, logic [DATA_W-1:0] val);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.opcode      <= op;
        req_bus.lookup_key  <= key;
        req_bus.store_value <= val;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        pending_answers.push_back(predict_access(op, key, val));
        words_sent++;
    endtask

    // drains the block, then writes the capacity register
    task automatic set_capacity(logic [CFG_W-1:0] cap);
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge i_clk);
        cfg_wr_en    <= 1'b0;
        capacity_reg = cap;
        capacity_writes++;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1: begin
                sender_idle_pct    = 87;
                receiver_stall_pct = 0;
            end
            2: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 87;
            end
            default: begin
                sender_idle_pct    = 11;
                receiver_stall_pct = 11;
            end
        endcase
    endtask

    task automatic test_basic_access();
        send_word(OP_GET, 32'h0000_0000, 32'h1234_5678);
        send_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(OP_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
        send_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
    endtask

    // capacity dropped below occupancy: every put miss evicts exactly one entry
    task automatic test_eviction_order();
        set_capacity(CFG_W'(2));
        send_word(OP_PUT, 32'h0000_1001, 32'hAAAA_0001);
        send_word(OP_PUT, 32'h0000_1002, 32'hAAAA_0002);
        send_word(OP_GET, 32'h0000_1001, 32'h0000_0000);
        send_word(OP_PUT, 32'h0000_1003, 32'hAAAA_0003);
        send_word(OP_GET, 32'h0000_1002, 32'h0000_0000);
    endtask

    task automatic test_capacity_limits();
        set_capacity(CFG_W'(0));
        send_word(OP_PUT, 32'h0000_2001, 32'hBBBB_0001);
        send_word(OP_GET, 32'h0000_2001, 32'h0000_0000);
        send_word(OP_GET, 32'h0000_1001, 32'h0000_0000);
        // above the table size acts as the table size
        set_capacity(CFG_W'(31));
        send_word(OP_PUT, 32'h0000_2002, 32'hBBBB_0002);
        send_word(OP_GET, 32'h0000_2002, 32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] cap_plan [PHASES];
        logic [KEY_W-1:0] key_pool [32];
        logic [KEY_W-1:0] key;
        int               span;
        int               cap_eff;
        cap_plan = '{CFG_W'(16), CFG_W'(31), CFG_W'(1), CFG_W'(0), CFG_W'(5), CFG_W'(17),
                     CFG_W'(2), CFG_W'($urandom_range(31)), CFG_W'(12), CFG_W'(16),
                     CFG_W'(3), CFG_W'($urandom_range(31))};
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 32; i++)
            key_pool[i] = $urandom;
        for (int phase = 0; phase < PHASES; phase++) begin
            set_capacity(cap_plan[phase]);
            set_idling(phase % 4);
            cap_eff = (cap_plan[phase] > CAPACITY_MAX) ? CAPACITY_MAX : int'(cap_plan[phase]);
            // a key set slightly larger than the capacity gives both hits and evictions
            span = cap_eff + 6;
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 80)
                    key = key_pool[$urandom_range(span - 1)];
                else
                    key = $urandom;
                send_word(t_op'($urandom_range(1)), key, $urandom);
            end
        end
    endtask

    always @(posedge i_clk) begin : response_check
        t_answer want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected word found=%0b value=%h",
                                          rsp_bus.found, rsp_bus.read_value));
            end else begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (rsp_bus.found !== want.found)
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              rsp_bus.found, want.found));
                if (rsp_bus.read_value !== want.value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              rsp_bus.read_value, want.value));
            end
        end
        rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ends the run when no word moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no word accepted for %0d cycles", QUIET_LIMIT);
        $display("lfu_cache_table: mismatch");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_bus.valid       = 1'b0;
        req_bus.opcode      = 1'b0;
        req_bus.lookup_key  = '0;
        req_bus.store_value = '0;
        rsp_bus.ready       = 1'b0;
        mismatches          = 0;
        words_sent          = 0;
        answers_checked     = 0;
        capacity_writes     = 0;
        sender_idle_pct     = 0;
        receiver_stall_pct  = 0;
        for (int i = 0; i < CAPACITY_MAX; i++) begin
            ent_valid[i] = 1'b0;
            ent_key[i]   = '0;
            ent_data[i]  = '0;
            ent_uses[i]  = '0;
            ent_stamp[i] = '0;
        end
        touch_clock  = '0;
        occupancy    = 0;
        capacity_reg = CAP_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_access();
        test_eviction_order();
        test_capacity_limits();
        test_random_traffic();

        req_bus.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d words, checked %0d answers over %0d capacity settings",
                 words_sent, answers_checked, capacity_writes);
        $display("idling: none, sender 87%%, receiver 87%%, both 11%%; %0d errors",
                 mismatches);
        if (mismatches == 0)
            $display("lfu_cache_table: match");
        else
            $display("lfu_cache_table: mismatch");
        $finish;
    end

endmodule
